// ----- rtl/bce_pkg.sv -----
// Shared types, operation codes and the CRC byte step for the byte checksum engine.
// Has no dependencies. All other rtl files refer to it by scoped names.
`default_nettype none

package bce_pkg;

	localparam int unsigned OpW = 3;

	localparam logic [OpW-1:0] OP_PASS   = 3'd0;
	localparam logic [OpW-1:0] OP_SUM    = 3'd1;
	localparam logic [OpW-1:0] OP_XOR    = 3'd2;
	localparam logic [OpW-1:0] OP_INVERT = 3'd3;
	localparam logic [OpW-1:0] OP_CRC16  = 3'd4;

	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] result_value;
		logic        is_check;
	} res_t;

	// Reflected CRC-16, eight shifts of one byte unrolled
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/bce_in_reg.sv -----
// Input register stage of the byte checksum engine: holds one request until it moves on.
// Depends on bce_pkg for the item type.
`default_nettype none

module bce_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire bce_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               s1_valid,
	output bce_pkg::item_t     s1_item
);

	logic           valid_s1;
	bce_pkg::item_t item_s1;

	// Take a new request when empty or when the held one leaves this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

endmodule

`default_nettype wire

// ----- rtl/bce_accum.sv -----
// Accumulators (sum, xor, CRC) and the per-byte result logic of the byte checksum engine.
// Depends on bce_pkg for codes, types and the CRC byte step.
`default_nettype none

module bce_accum (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    fire,
	input  wire bce_pkg::item_t          item,
	input  wire logic [bce_pkg::OpW-1:0] operation,
	output bce_pkg::res_t                res
);

	logic [31:0] sum_q;
	logic [7:0]  xor_q;
	logic [15:0] crc_q;

	logic [31:0] sum_nxt;
	logic [7:0]  xor_nxt;
	logic [15:0] crc_nxt;

	assign sum_nxt = sum_q + {24'd0, item.data_byte};
	assign xor_nxt = xor_q ^ item.data_byte;
	assign crc_nxt = bce_pkg::crc_byte(crc_q, item.data_byte);

	always_comb begin
		res = '0;
		unique case (operation)
			bce_pkg::OP_PASS: begin
				res.valid        = 1'b1;
				res.result_value = {24'd0, item.data_byte};
			end
			bce_pkg::OP_INVERT: begin
				res.valid        = 1'b1;
				res.result_value = {24'd0, ~item.data_byte};
			end
			bce_pkg::OP_SUM: begin
				res.valid        = item.last_byte;
				res.is_check     = 1'b1;
				res.result_value = sum_nxt;
			end
			bce_pkg::OP_XOR: begin
				res.valid        = item.last_byte;
				res.is_check     = 1'b1;
				res.result_value = {24'd0, xor_nxt};
			end
			bce_pkg::OP_CRC16: begin
				res.valid        = item.last_byte;
				res.is_check     = 1'b1;
				res.result_value = {16'd0, crc_nxt};
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Only the accumulator of the current mode moves; a last byte clears all three
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			xor_q <= '0;
			crc_q <= '0;
		end else if (fire) begin
			if (item.last_byte) begin
				sum_q <= '0;
				xor_q <= '0;
				crc_q <= '0;
			end else begin
				if (operation == bce_pkg::OP_SUM)   sum_q <= sum_nxt;
				if (operation == bce_pkg::OP_XOR)   xor_q <= xor_nxt;
				if (operation == bce_pkg::OP_CRC16) crc_q <= crc_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/byte_checksum_engine.sv -----
// Top level of the byte checksum engine: config register, input stage, accumulators, output register.
// Depends on bce_pkg, bce_in_reg and bce_accum.
`default_nettype none

// Takes one byte per clock cycle while the output is not stalled; each accepted byte is
// held in the input register and its result in the result register. The eight CRC
// shifts of a byte are unrolled into combinational xor logic next to the sum and xor
// accumulators, so every mode sustains one byte per cycle unless the output stalls.
// Pass-through and invert give one result per byte; sum, xor and crc give one result,
// flagged in tuser, on the byte marked by tlast, after which all accumulators clear. Write the
// operation only while the stream is idle; the register write does not clear the accumulators.
module byte_checksum_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data,      // [2:0] operation
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tlast,  // last_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [31:0] result_value
	output logic             m_axis_tuser   // [0] is_check
);

	logic [bce_pkg::OpW-1:0] op_q;
	logic                    s1_valid;
	bce_pkg::item_t          in_item;
	bce_pkg::item_t          s1_item;
	bce_pkg::res_t           res;
	logic                    advance;
	logic                    fire;
	logic                    out_valid_q;
	logic [31:0]             out_value_q;
	logic                    out_check_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= bce_pkg::OP_PASS;
		end else if (cfg_valid) begin
			op_q <= cfg_data;
		end
	end

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.last_byte = s_axis_tlast;

	// Stage 1 moves on whenever the result register is free or being drained
	assign advance = !out_valid_q || m_axis_tready;
	assign fire    = s1_valid && advance;

	bce_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	bce_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (s1_item),
		.operation (op_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			out_value_q <= res.result_value;
			out_check_q <= res.is_check;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_check_q;

	// A full input stage that cannot move on must refuse new requests
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |-> !s_axis_tready)
		else $error("input stage accepted a request while stalled");

	// A byte result carries only eight significant bits
	a_byte_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:8] == 24'd0)
		else $error("byte result wider than eight bits");

	// A CRC result carries only sixteen significant bits
	a_crc_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser && op_q == bce_pkg::OP_CRC16
		|-> m_axis_tdata[31:16] == 16'd0)
		else $error("crc result wider than sixteen bits");

	// A result only appears from a byte that left the input stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid ##1 m_axis_tvalid |-> $past(fire))
		else $error("result appeared without a byte leaving stage 1");

endmodule

`default_nettype wire

// ----- tb/sv/bce_result_checker.sv -----
// Result checker for the byte checksum engine: follows the operation register and the
// byte stream, predicts each result and compares it with the output stream.
// Depends on bce_pkg for the operation codes and the CRC polynomial.

module bce_result_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_data,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,
	input  wire logic        s_axis_tlast,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,
	input  wire logic        m_axis_tuser,
	output int               fail_count,
	output int               pending,
	output int               results_checked,
	output int               checks_checked
);
	import bce_pkg::*;

	localparam int ShownMismatches = 10;

	typedef struct packed {
		logic [31:0] value;
		logic        is_check;
	} outcome_t;

	outcome_t          expected_results[$];
	logic [OpW-1:0]    operation;
	logic [31:0]       sum_total;
	logic [7:0]        xor_total;
	logic [15:0]       crc_register;

	function automatic logic [15:0] crc16_arc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	// Fold one byte into the accumulator of the current operation and queue its result
	function automatic void predict_byte(input logic [7:0] b, input logic l);
		outcome_t o;
		logic     produced;
		o = '0;
		produced = 1'b0;
		case (operation)
			OP_PASS: begin
				o.value = {24'h0, b};
				produced = 1'b1;
			end
			OP_INVERT: begin
				o.value = {24'h0, ~b};
				produced = 1'b1;
			end
			OP_SUM: begin
				sum_total = sum_total + {24'h0, b};
				o = '{sum_total, 1'b1};
				produced = l;
			end
			OP_XOR: begin
				xor_total = xor_total ^ b;
				o = '{{24'h0, xor_total}, 1'b1};
				produced = l;
			end
			OP_CRC16: begin
				crc_register = crc16_arc_step(crc_register, b);
				o = '{{16'h0, crc_register}, 1'b1};
				produced = l;
			end
			default: begin
				produced = 1'b0;
			end
		endcase
		// end of message clears every accumulator, whatever the operation
		if (l) begin
			sum_total = '0;
			xor_total = '0;
			crc_register = '0;
		end
		if (produced)
			expected_results.push_back(o);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			operation = OP_PASS;
			sum_total = '0;
			xor_total = '0;
			crc_register = '0;
			expected_results.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tuser};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= ShownMismatches)
						$display("unexpected result: value %h check %b", got.value, got.is_check);
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.is_check)
						checks_checked++;
					if (got !== want) begin
						fail_count++;
						if (fail_count <= ShownMismatches)
							$display("mismatch on result %0d: expected value %h check %b, got value %h check %b",
								results_checked, want.value, want.is_check, got.value, got.is_check);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				operation = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				predict_byte(s_axis_tdata, s_axis_tlast);
		end
		pending = expected_results.size();
	end

endmodule

// ----- tb/sv/byte_checksum_engine_tb.sv -----
// Top of the byte checksum engine testbench: clock, reset, request stimulus and verdict.
// Depends on bce_pkg, the engine RTL and bce_result_checker.

module byte_checksum_engine_tb;
	import bce_pkg::*;

	localparam logic [OpW-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;
	localparam int RandomBytes   = 1600;
	localparam int WatchdogLimit = 2000;
	localparam int BusyPct       = 32;

	logic            clk;
	logic            arst_n;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [OpW-1:0]  cfg_data;
	logic            s_axis_tvalid;
	logic            s_axis_tready;
	logic [7:0]      s_axis_tdata;
	logic            s_axis_tlast;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	logic [31:0]     m_axis_tdata;
	logic            m_axis_tuser;

	int fail_count;
	int pending;
	int results_checked;
	int checks_checked;
	int idle_pct  = BusyPct;
	int stall_pct = BusyPct;
	int bytes_sent;
	int settings_used;

	byte_checksum_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	bce_result_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked),
		.checks_checked  (checks_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL byte_checksum_engine");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= l;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	// Hold the stream until every result is out, then let the pipeline empty
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_operation(input logic [OpW-1:0] op);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= op;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_message(input int len, input logic complete);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), complete && (i == len - 1));
	endtask

	initial begin : stimulus
		logic [OpW-1:0] op;
		int             random_bytes;
		int             phase;
		int             n_msgs;
		int             len;
		random_bytes = 0;
		phase = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = OP_PASS;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pass-through straight after reset, then each mode at its field extremes
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);
		set_operation(OP_INVERT);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		set_operation(OP_SUM);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'h00, 1'b1);
		set_operation(OP_XOR);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hFF, 1'b1);
		set_operation(OP_CRC16);
		send_byte(8'h31, 1'b0);
		send_byte(8'h32, 1'b0);
		send_byte(8'h33, 1'b1);
		send_byte(8'hFF, 1'b1);
		// a last byte under an unused code still clears the sum
		set_operation(OP_SUM);
		send_byte(8'h10, 1'b0);
		set_operation(OP_SPARE_LO);
		send_byte(8'h77, 1'b1);
		set_operation(OP_SUM);
		send_byte(8'h01, 1'b1);
		// only the current mode's accumulator moves; a mid-message switch picks it up again
		send_byte(8'h20, 1'b0);
		set_operation(OP_XOR);
		send_byte(8'h0F, 1'b1);
		set_operation(OP_SUM);
		send_byte(8'h30, 1'b0);
		set_operation(OP_CRC16);
		send_byte(8'h01, 1'b0);
		set_operation(OP_SUM);
		send_byte(8'h02, 1'b1);
		set_operation(OP_SPARE_HI);
		send_byte(8'hC3, 1'b0);

		while (random_bytes < RandomBytes) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3:     op = OP_PASS;
				4, 5, 6, 7:     op = OP_SUM;
				8, 9, 10:       op = OP_XOR;
				11, 12, 13:     op = OP_INVERT;
				14, 15, 16, 17: op = OP_CRC16;
				default:        op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			endcase
			if (phase >= 20 && phase < 35) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				idle_pct = BusyPct;
				stall_pct = BusyPct;
			end
			set_operation(op);
			n_msgs = $urandom_range(1, 6);
			for (int m = 0; m < n_msgs; m++) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
				// now and then leave the last message open for the next setting to carry on
				send_message(len, (m != n_msgs - 1) || ($urandom_range(0, 5) != 0));
				if (op <= OP_CRC16)
					random_bytes += len;
				if ($urandom_range(0, 5) == 0)
					wait_drained();
			end
			phase++;
		end

		wait_drained();
		repeat (6) @(negedge clk);
		$display("Sent %0d bytes across %0d operation settings, with open messages carried over.",
			bytes_sent, settings_used);
		$display("Checked %0d results, %0d of them end-of-message checksums.",
			results_checked, checks_checked);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS byte_checksum_engine");
		end else begin
			$display("FAIL byte_checksum_engine");
		end
		$finish;
	end

endmodule
